// ===== src/tick_driven_melody_sequencer_core_macros.svh =====
// Assertion macros shared by the melody sequencer checker.
// Depends on nothing; included by the checker file.
`ifndef TICK_DRIVEN_MELODY_SEQUENCER_CORE_MACROS_SVH
`define TICK_DRIVEN_MELODY_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDMS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("melody sequencer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TDMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("melody sequencer assertion failed");

`endif

// ===== src/tdms_pkg.sv =====
// Shared types, constants and lookup functions of the melody sequencer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package tdms_pkg;

    localparam int NOTE_DEPTH = 64;
    localparam int NOTE_AW    = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int PTR_W      = 7;
    localparam int BOUND_W    = ($clog2(NOTE_DEPTH + 1) > PTR_W) ?
                                $clog2(NOTE_DEPTH + 1) : PTR_W;
    localparam int ENTRY_W    = 14;
    localparam int CODE_W     = 7;
    localparam int RATE_W     = 14;
    localparam int BEAT_W     = 8;
    localparam int REP_W      = 4;
    localparam int MCAND_W    = BEAT_W + REP_W;
    localparam int PROD_W     = MCAND_W + RATE_W;
    localparam int MCNT_W     = $clog2(RATE_W);
    localparam int TC_W       = 16;
    localparam int PERIOD_W   = 20;
    localparam int CFG_DATA_W = 14;

    localparam logic [PERIOD_W-1:0] SILENT_PERIOD = 20'd999999;
    localparam logic [RATE_W-1:0]   RATE_RESET    = 14'd1000;

    typedef enum logic [1:0] {
        CFG_TICK_RATE   = 2'd0,
        CFG_START_INDEX = 2'd1,
        CFG_END_INDEX   = 2'd2
    } cfg_reg_t;

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LIM,
        ST_LIM_SETUP,
        ST_MUL,
        ST_CMP,
        ST_RD_NOTE,
        ST_SOUND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              func;
        logic [5:0]        note_index;
        logic [CODE_W-1:0] pitch_code;
        logic [CODE_W-1:0] duration_code;
        logic              enable;
    } in_t;

    typedef struct packed {
        logic                tone_active;
        logic [PERIOD_W-1:0] timer_period;
        logic [1:0]          pitch_level;
        logic [2:0]          pitch_step;
        logic                playing;
        logic                finished;
    } out_t;

    typedef struct packed {
        logic               start;
        logic [MCAND_W-1:0] mcand;
        logic [RATE_W-1:0]  mplier;
    } mul_req_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // Decimal split of a code below 128: n*205>>11 equals n/10 over this range.
    function automatic digits_t split_digits(input logic [CODE_W-1:0] code);
        logic [CODE_W+7:0] scaled;
        digits_t           d;
        scaled  = (CODE_W + 8)'(code) * (CODE_W + 8)'(8'd205);
        d.tens  = scaled[CODE_W+7:11];
        d.units = 4'(code - CODE_W'(d.tens) * CODE_W'(4'd10));
        return d;
    endfunction

    function automatic logic [BEAT_W-1:0] beat_ms(input logic [2:0] idx);
        logic [BEAT_W-1:0] ms;
        case (idx)
            3'd0:    ms = 8'd0;
            3'd1:    ms = 8'd62;
            3'd2:    ms = 8'd94;
            3'd3:    ms = 8'd125;
            3'd4:    ms = 8'd125;
            3'd5:    ms = 8'd187;
            default: ms = 8'd250;
        endcase
        return ms;
    endfunction

    // Timer reload 1000000/freq - 1 for each octave and scale step.
    function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] lvl,
                                                      input logic [2:0] stp);
        logic [PERIOD_W-1:0] p;
        case ({lvl, stp})
            5'b00_001: p = 20'd3830;
            5'b00_010: p = 20'd3411;
            5'b00_011: p = 20'd3038;
            5'b00_100: p = 20'd2864;
            5'b00_101: p = 20'd2556;
            5'b00_110: p = 20'd2271;
            5'b00_111: p = 20'd2027;
            5'b01_001: p = 20'd1911;
            5'b01_010: p = 20'd1702;
            5'b01_011: p = 20'd1516;
            5'b01_100: p = 20'd1431;
            5'b01_101: p = 20'd1276;
            5'b01_110: p = 20'd1135;
            5'b01_111: p = 20'd1012;
            5'b10_001: p = 20'd955;
            5'b10_010: p = 20'd850;
            5'b10_011: p = 20'd757;
            5'b10_100: p = 20'd715;
            5'b10_101: p = 20'd637;
            5'b10_110: p = 20'd567;
            5'b10_111: p = 20'd505;
            default:   p = SILENT_PERIOD;
        endcase
        return p;
    endfunction

endpackage

// ===== src/tick_driven_melody_sequencer_core.sv =====
// Top level of the tick-driven buzzer melody sequencer.
// Depends on tdms_pkg, tdms_note_ram and tdms_serial_mul.
`timescale 1ns / 1ps

// Buzzer melody player driven by ticks. A beat with func low writes a pitch code and a
// duration code into the 64-entry note store; a beat with func high is one tick. An
// enabled tick while idle starts the melody at start_index, and later enabled ticks
// count against the current note's duration, beat_ms * repeats * tick_rate_hz / 1000,
// moving to the next note once the count exceeds it. The melody stops before
// end_index, silencing the tone and pulsing finished; a disabled tick silences at once.
// Every beat in gives exactly one beat out carrying the timer reload of the tone
// (999999 when silent) and the playback flags. One item is worked on at a time. A load,
// a disabled tick or an empty melody goes straight to output; a start reads its note
// from the store and sounds it; a tick of a running melody reads the note, feeds the
// bit-serial multiplier, which walks the 14 bits of tick_rate_hz one per cycle,
// compares, and reads and sounds the new note when it advances. The output register
// lets a new beat be accepted while the previous result still waits.
// Configuration writes are taken at any time and should only be issued while idle;
// there is no clearing pass, and notes must be loaded before they are played.

module tick_driven_melody_sequencer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tdms_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tdms_pkg::out_t                    out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [tdms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tdms_pkg::*;

    // Control state of the sequencer.
    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [TC_W-1:0]     tc_reg, tc_next;
    logic                run_reg, run_next;
    logic                fin_reg, fin_next;
    logic                out_valid_reg, out_valid_next;

    // Sounding tone, kept as payload.
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [1:0]          lvl_reg, lvl_next;
    logic [2:0]          stp_reg, stp_next;
    logic [PROD_W-1:0]   q_reg, q_next;
    out_t                out_reg, out_next;

    // Configuration registers.
    logic [RATE_W-1:0]   rate_reg;
    logic [5:0]          start_reg;
    logic [6:0]          end_reg;

    logic                accept;
    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    mul_req_t            mul_req;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_prod;

    logic [BOUND_W-1:0]  end_ext;
    logic [BOUND_W-1:0]  end_bound;
    logic [BOUND_W-1:0]  start_ext;
    logic [PTR_W-1:0]    ptr_inc;
    digits_t             dur_digits;
    digits_t             pitch_digits;
    logic [2:0]          beat_idx;
    logic [1:0]          note_lvl;
    logic [2:0]          note_stp;
    logic                out_free;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // The end index is clipped to the store depth.
    assign end_ext   = BOUND_W'(end_reg);
    assign end_bound = (end_ext > BOUND_W'(NOTE_DEPTH)) ? BOUND_W'(NOTE_DEPTH) : end_ext;
    assign start_ext = BOUND_W'(start_reg);
    assign ptr_inc   = ptr_reg + 1'b1;

    // Out-of-table digits clamp to the last table entry.
    assign dur_digits   = split_digits(ram_rdata[ENTRY_W-1:CODE_W]);
    assign pitch_digits = split_digits(ram_rdata[CODE_W-1:0]);
    assign beat_idx = (dur_digits.tens > 4'd6) ? 3'd6 : dur_digits.tens[2:0];
    assign note_lvl = (pitch_digits.tens > 4'd2) ? 2'd2 : pitch_digits.tens[1:0];
    assign note_stp = (pitch_digits.units > 4'd7) ? 3'd7 : pitch_digits.units[2:0];

    // Loads write the store at acceptance; slots beyond the depth are dropped.
    assign ram_we = accept && (in_data.func == FUNC_LOAD) &&
                    (BOUND_W'(in_data.note_index) < BOUND_W'(NOTE_DEPTH));

    tdms_note_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (NOTE_AW'(in_data.note_index)),
        .wdata ({in_data.duration_code, in_data.pitch_code}),
        .re    (ram_re),
        .raddr (NOTE_AW'(ptr_reg)),
        .rdata (ram_rdata)
    );

    tdms_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.func == FUNC_LOAD || !in_data.enable)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (run_reg)
                    begin
                        state_next = ST_RD_LIM;
                    end
                    else if (start_ext >= end_bound)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_RD_NOTE;
                    end
                end
            end
            ST_RD_LIM:    state_next = ST_LIM_SETUP;
            ST_LIM_SETUP: state_next = ST_MUL;
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // The count exceeds the limit exactly when the full product is below
                // count * 1000, which avoids dividing by 1000.
                if (mul_prod < q_reg && BOUND_W'(ptr_inc) < end_bound)
                begin
                    state_next = ST_RD_NOTE;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RD_NOTE:   state_next = ST_SOUND;
            ST_SOUND:     state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Handshake and unit controls decoded from the state.
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        ram_re         = (state_reg == ST_RD_LIM) || (state_reg == ST_RD_NOTE);
        mul_req.start  = (state_reg == ST_LIM_SETUP);
        mul_req.mcand  = MCAND_W'(beat_ms(beat_idx)) * MCAND_W'(dur_digits.units);
        mul_req.mplier = rate_reg;
    end

    // Datapath updates.
    always_comb
    begin
        ptr_next       = ptr_reg;
        tc_next        = tc_reg;
        run_next       = run_reg;
        fin_next       = fin_reg;
        period_next    = period_reg;
        lvl_next       = lvl_reg;
        stp_next       = stp_reg;
        q_next         = q_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fin_next = 1'b0;
                    if (in_data.func == FUNC_TICK)
                    begin
                        if (!in_data.enable)
                        begin
                            period_next = SILENT_PERIOD;
                            lvl_next    = '0;
                            stp_next    = '0;
                            run_next    = 1'b0;
                        end
                        else if (!run_reg)
                        begin
                            ptr_next = PTR_W'(start_reg);
                            tc_next  = '0;
                            if (start_ext >= end_bound)
                            begin
                                period_next = SILENT_PERIOD;
                                lvl_next    = '0;
                                stp_next    = '0;
                                fin_next    = 1'b1;
                            end
                            else
                            begin
                                run_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_LIM_SETUP:
            begin
                // count * 1000 as count * 1024 - count * 16 - count * 8.
                q_next = {tc_reg, 10'b0} - PROD_W'({tc_reg, 4'b0}) - PROD_W'({tc_reg, 3'b0});
            end
            ST_CMP:
            begin
                if (mul_prod < q_reg)
                begin
                    tc_next  = '0;
                    ptr_next = ptr_inc;
                    if (BOUND_W'(ptr_inc) >= end_bound)
                    begin
                        period_next = SILENT_PERIOD;
                        lvl_next    = '0;
                        stp_next    = '0;
                        run_next    = 1'b0;
                        fin_next    = 1'b1;
                    end
                end
                else if (tc_reg != '1)
                begin
                    tc_next = tc_reg + 1'b1;
                end
            end
            ST_SOUND:
            begin
                if (note_stp == 3'd0)
                begin
                    period_next = SILENT_PERIOD;
                    lvl_next    = '0;
                    stp_next    = '0;
                end
                else
                begin
                    period_next = period_of(note_lvl, note_stp);
                    lvl_next    = note_lvl;
                    stp_next    = note_stp;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_next.tone_active  = (stp_reg != 3'd0);
                    out_next.timer_period = period_reg;
                    out_next.pitch_level  = lvl_reg;
                    out_next.pitch_step   = stp_reg;
                    out_next.playing      = run_reg;
                    out_next.finished     = fin_reg;
                    out_valid_next        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            tc_reg        <= '0;
            run_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= SILENT_PERIOD;
            lvl_reg       <= '0;
            stp_reg       <= '0;
            rate_reg      <= RATE_RESET;
            start_reg     <= '0;
            end_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            tc_reg        <= tc_next;
            run_reg       <= run_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            period_reg    <= period_next;
            lvl_reg       <= lvl_next;
            stp_reg       <= stp_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TICK_RATE:   rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_START_INDEX: start_reg <= cfg_data[5:0];
                    CFG_END_INDEX:   end_reg   <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/tdms_note_ram.sv =====
// Note store: one write port and one registered read port.
// Depends on tdms_pkg for depth and word width.
`timescale 1ns / 1ps

module tdms_note_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [tdms_pkg::NOTE_AW-1:0]   waddr,
    input  logic [tdms_pkg::ENTRY_W-1:0]   wdata,
    input  logic                           re,
    input  logic [tdms_pkg::NOTE_AW-1:0]   raddr,
    output logic [tdms_pkg::ENTRY_W-1:0]   rdata
);
    import tdms_pkg::*;

    logic [ENTRY_W-1:0] mem [NOTE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tdms_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tdms_pkg for operand widths and the request struct.
`timescale 1ns / 1ps

module tdms_serial_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdms_pkg::mul_req_t            req,
    output logic                          done,
    output logic [tdms_pkg::PROD_W-1:0]   product
);
    import tdms_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MCNT_W-1:0]  cnt_reg, cnt_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [MCAND_W-1:0] hi_reg, hi_next;
    logic [RATE_W-1:0]  lo_reg, lo_next;
    logic [MCAND_W:0]   sum;

    // The low half holds the remaining multiplier bits; the sum shifts in from the top.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = req.mcand;
            hi_next    = '0;
            lo_next    = req.mplier;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[MCAND_W:1];
            lo_next  = {sum[0], lo_reg[RATE_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MCNT_W'(RATE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== src/tdms_checker.sv =====
// Port-level assertions for the melody sequencer, bound to the top level.
// Depends on tdms_pkg and the macro header.
`timescale 1ns / 1ps
`include "tick_driven_melody_sequencer_core_macros.svh"

module tdms_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input tdms_pkg::out_t out_data
);
    import tdms_pkg::*;

    // One item is in flight at a time, so ready drops right after a beat is taken.
    `TDMS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // A stalled result holds its value.
    `TDMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // Finishing a melody leaves the block idle and quiet.
    `TDMS_ASSERT_IMP(a_finish_quiet, clk, rst_n, out_valid && out_data.finished, !out_data.playing && !out_data.tone_active)

    // Silence always carries the silent reload and a zero step.
    `TDMS_ASSERT_IMP(a_silent_period, clk, rst_n, out_valid && !out_data.tone_active, out_data.timer_period == SILENT_PERIOD && out_data.pitch_step == 3'd0)

endmodule

bind tick_driven_melody_sequencer_core tdms_checker u_tdms_checker (.*);
